[rtl/vrst_pkg.sv]
// types and constants shared by the versioned range sum table
`default_nettype none
package vrst_pkg;

  localparam int SUM_W = 42;

  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_COPY   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_BAD_VER   = 3'd1;
  localparam logic [2:0] STS_BAD_POS   = 3'd2;
  localparam logic [2:0] STS_POOL_FULL = 3'd3;
  localparam logic [2:0] STS_VER_FULL  = 3'd4;

  typedef struct packed {
    logic [1:0]         action;
    logic [10:0]        version;
    logic [10:0]        position;
    logic signed [31:0] value;
    logic [10:0]        range_low;
    logic [10:0]        range_high;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic [10:0]             new_version;
    logic [2:0]              status;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_UPD_NODE,
    ST_UPD_SIB,
    ST_UPD_WR,
    ST_QRY_VISIT,
    ST_QRY_NODE
  } state_e;

endpackage
`default_nettype wire

[rtl/versioned_range_sum_table_unit.sv]
// persistent segment tree of range sums with a versioned root table
// error, no-op action or empty range finish straight from idle; copy ends after the root lookup; update
//   walks the path down to the leaf, then writes a new copy of each node on it back up; query visits
//   each node in turn, reading only those that overlap the range
// throughput: one word at a time, busy until the result word, the single node memory read port sets the pace
// reset initialises control registers and counters; version 1 reads as the null tree until written,
//   no memory clearing pass; the receiver cannot stall results
`default_nettype none
module versioned_range_sum_table_unit #(
  parameter int MAX_POSITIONS = 1024,
  parameter int MAX_VERSIONS  = 1024,
  parameter int NODE_POOL     = 65536
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire vrst_pkg::in_word_t   req_i,
  output logic                      done_o,
  output vrst_pkg::out_word_t       rsp_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [10:0]          cfg_data_i
);
  import vrst_pkg::*;

  localparam int NW   = $clog2(NODE_POOL);
  localparam int LW   = $clog2(MAX_POSITIONS + 1);
  localparam int PW   = (LW > 11) ? LW : 11;
  localparam int VW   = $clog2(MAX_VERSIONS + 1);
  localparam int CVW  = (VW > 11) ? VW : 11;
  localparam int VAW  = $clog2(MAX_VERSIONS);
  localparam int H    = $clog2(MAX_POSITIONS);
  localparam int DW   = $clog2(H + 1);
  localparam int SIW  = (H > 1) ? $clog2(H) : 1;
  localparam int MW   = SUM_W + 2 * NW;
  localparam int ECNT_RST = (MAX_POSITIONS < 1024) ? MAX_POSITIONS : 1024;

  // memories
  logic [MW-1:0]  node_mem [NODE_POOL];
  logic [NW-1:0]  vr_mem   [MAX_VERSIONS];

  logic           n_re, n_we, vr_re, vr_we;
  logic [NW-1:0]  n_raddr, n_waddr;
  logic [MW-1:0]  n_wdata, n_rdata_q;
  logic           n_rzero_q;
  logic [VAW-1:0] vr_raddr, vr_waddr;
  logic [NW-1:0]  vr_wdata, vr_rdata_q;

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      node_mem[n_waddr] <= n_wdata;
    end
    if (n_re) begin
      n_rdata_q <= node_mem[n_raddr];
      n_rzero_q <= (n_raddr == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (vr_we) begin
      vr_mem[vr_waddr] <= vr_wdata;
    end
    if (vr_re) begin
      vr_rdata_q <= vr_mem[vr_raddr];
    end
  end

  // entry 0 is the null node
  logic [SUM_W-1:0] n_sum;
  logic [NW-1:0]    n_left, n_right;
  assign n_sum   = n_rzero_q ? '0 : n_rdata_q[MW-1 -: SUM_W];
  assign n_left  = n_rzero_q ? '0 : n_rdata_q[2*NW-1:NW];
  assign n_right = n_rzero_q ? '0 : n_rdata_q[NW-1:0];

  // registers
  state_e           state_q, state_d;
  logic [PW-1:0]    ecount_q;
  logic [NW-1:0]    nodes_used_q, nodes_used_d;
  logic [VW-1:0]    ver_total_q, ver_total_d;
  logic             v1_ok_q, v1_ok_d;
  logic             done_q, done_d;
  out_word_t        res_q, res_d;

  logic [1:0]       act_q, act_d;
  logic [10:0]      ver_q, ver_d;
  logic [VAW-1:0]   vaddr_q, vaddr_d;
  logic [PW-1:0]    pos_q, pos_d, a_q, a_d, b_q, b_d, lo_q, lo_d, hi_q, hi_d;
  logic [SUM_W-1:0] val_q, val_d, acc_q, acc_d, chsum_q, chsum_d;
  logic [NW-1:0]    cur_q, cur_d, chid_q, chid_d;
  logic [DW-1:0]    dep_q, dep_d, qsp_q, qsp_d;

  // update path stack and query pending stack
  logic             ustk_dir_q [H];
  logic [NW-1:0]    ustk_sib_q [H];
  logic [SUM_W-1:0] ustk_sum_q [H];
  logic [NW-1:0]    qstk_node_q [H];
  logic [PW-1:0]    qstk_lo_q [H];
  logic [PW-1:0]    qstk_hi_q [H];
  logic             ustk_we_link, ustk_we_sum, qstk_push;
  logic             ustk_dir_w;
  logic [NW-1:0]    ustk_sib_w;

  // shared conditions
  logic             accept, v_bad, pos_bad, ver_full, rng_empty, imm_done;
  logic [CVW-1:0]   v_ext, v_m1;
  logic [PW-1:0]    p_ext, ra_ext, rb_ext, mid;
  logic [PW:0]      mid_sum;
  logic             go_left, leaf, covered, disjoint, pool_full, qsp_empty, wr_last;
  logic [NW:0]      pool_need;
  logic [DW-1:0]    dep_m1, qsp_m1;
  logic [SIW-1:0]   ws_idx, rs_idx, qp_idx, qr_idx;
  logic [NW-1:0]    root_s;

  assign accept    = start && !busy;
  assign v_ext     = CVW'(req_i.version);
  assign v_m1      = v_ext - CVW'(1);
  assign p_ext     = PW'(req_i.position);
  assign ra_ext    = PW'(req_i.range_low);
  assign rb_ext    = PW'(req_i.range_high);
  assign v_bad     = (v_ext == '0) || (v_ext > CVW'(ver_total_q));
  assign pos_bad   = (p_ext == '0) || (p_ext > ecount_q);
  assign ver_full  = (ver_total_q >= VW'(MAX_VERSIONS));
  assign rng_empty = (ra_ext > rb_ext);
  assign imm_done  = (req_i.action == ACT_NONE) || v_bad ||
                     ((req_i.action == ACT_UPDATE) && pos_bad) ||
                     ((req_i.action == ACT_COPY) && ver_full) ||
                     ((req_i.action == ACT_QUERY) && rng_empty);

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[PW:1];
  assign go_left   = (pos_q <= mid);
  assign leaf      = !(lo_q < hi_q);
  assign covered   = (a_q <= lo_q) && (b_q >= hi_q);
  assign disjoint  = (hi_q < a_q) || (b_q < lo_q);
  assign pool_need = {1'b0, nodes_used_q} + (NW+1)'(dep_q) + (NW+1)'(1);
  assign pool_full = (pool_need > (NW+1)'(NODE_POOL - 1));
  assign qsp_empty = (qsp_q == '0);
  assign wr_last   = (dep_q == DW'(1));
  assign dep_m1    = dep_q - DW'(1);
  assign qsp_m1    = qsp_q - DW'(1);
  assign ws_idx    = dep_q[SIW-1:0];
  assign rs_idx    = dep_m1[SIW-1:0];
  assign qp_idx    = qsp_q[SIW-1:0];
  assign qr_idx    = qsp_m1[SIW-1:0];
  assign root_s    = ((ver_q == 11'd1) && !v1_ok_q) ? '0 : vr_rdata_q;

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = res_q;
  assign cfg_ready_o = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !imm_done) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (act_q == ACT_UPDATE)     state_d = ST_UPD_NODE;
        else if (act_q == ACT_QUERY) state_d = ST_QRY_VISIT;
        else                         state_d = ST_IDLE;
      end
      ST_UPD_NODE: begin
        if (!leaf)                           state_d = ST_UPD_SIB;
        else if (pool_full || dep_q == '0)   state_d = ST_IDLE;
        else                                 state_d = ST_UPD_WR;
      end
      ST_UPD_SIB: state_d = ST_UPD_NODE;
      ST_UPD_WR: begin
        if (wr_last) state_d = ST_IDLE;
      end
      ST_QRY_VISIT: begin
        if (!disjoint)      state_d = ST_QRY_NODE;
        else if (qsp_empty) state_d = ST_IDLE;
      end
      ST_QRY_NODE: begin
        if (covered && qsp_empty) state_d = ST_IDLE;
        else                      state_d = ST_QRY_VISIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    logic [SUM_W-1:0] acc_n;
    logic [NW-1:0]    id_n;
    logic [SUM_W-1:0] sum_n;
    acc_n        = acc_q + n_sum;
    id_n         = chid_q + NW'(1);
    sum_n        = chsum_q + ustk_sum_q[rs_idx];
    nodes_used_d = nodes_used_q;
    ver_total_d  = ver_total_q;
    v1_ok_d      = v1_ok_q;
    done_d       = 1'b0;
    res_d        = res_q;
    act_d = act_q; ver_d = ver_q; vaddr_d = vaddr_q; pos_d = pos_q;
    a_d = a_q; b_d = b_q; lo_d = lo_q; hi_d = hi_q; val_d = val_q;
    acc_d = acc_q; chsum_d = chsum_q; cur_d = cur_q; chid_d = chid_q;
    dep_d = dep_q; qsp_d = qsp_q;
    n_re = 1'b0; n_raddr = cur_q;
    n_we = 1'b0; n_waddr = id_n; n_wdata = '0;
    vr_re = 1'b0; vr_raddr = v_m1[VAW-1:0];
    vr_we = 1'b0; vr_waddr = vaddr_q; vr_wdata = root_s;
    ustk_we_link = 1'b0; ustk_we_sum = 1'b0; qstk_push = 1'b0;
    ustk_dir_w = !go_left;
    ustk_sib_w = go_left ? n_right : n_left;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d   = req_i.action;
          ver_d   = req_i.version;
          vaddr_d = v_m1[VAW-1:0];
          pos_d   = p_ext;
          a_d     = ra_ext;
          b_d     = rb_ext;
          val_d   = {{(SUM_W-32){req_i.value[31]}}, req_i.value};
          if (imm_done) begin
            done_d = 1'b1;
            res_d  = '0;
            if (req_i.action == ACT_NONE)        res_d.status = STS_OK;
            else if (v_bad)                      res_d.status = STS_BAD_VER;
            else if (req_i.action == ACT_UPDATE) res_d.status = STS_BAD_POS;
            else if (req_i.action == ACT_COPY)   res_d.status = STS_VER_FULL;
            else                                 res_d.status = STS_OK;
          end else begin
            vr_re = 1'b1;
          end
        end
      end
      ST_ROOT: begin
        cur_d = root_s;
        lo_d  = PW'(1);
        hi_d  = ecount_q;
        dep_d = '0;
        qsp_d = '0;
        acc_d = '0;
        if (act_q == ACT_UPDATE) begin
          n_re    = 1'b1;
          n_raddr = root_s;
        end else if (act_q == ACT_COPY) begin
          vr_we       = 1'b1;
          vr_waddr    = ver_total_q[VAW-1:0];
          vr_wdata    = root_s;
          ver_total_d = ver_total_q + VW'(1);
          done_d      = 1'b1;
          res_d       = '0;
          res_d.new_version = 11'(ver_total_q + VW'(1));
          res_d.status      = STS_OK;
        end
      end
      ST_UPD_NODE: begin
        if (!leaf) begin
          ustk_we_link = 1'b1;
          cur_d   = go_left ? n_left : n_right;
          n_re    = 1'b1;
          n_raddr = ustk_sib_w;
          if (go_left) hi_d = mid;
          else         lo_d = mid + PW'(1);
        end else if (pool_full) begin
          done_d       = 1'b1;
          res_d        = '0;
          res_d.status = STS_POOL_FULL;
        end else begin
          // new leaf keeps the old leaf's links
          n_we    = 1'b1;
          n_waddr = nodes_used_q + NW'(1);
          n_wdata = {val_q, n_left, n_right};
          chid_d  = nodes_used_q + NW'(1);
          chsum_d = val_q;
          if (dep_q == '0) begin
            vr_we        = 1'b1;
            vr_wdata     = nodes_used_q + NW'(1);
            nodes_used_d = nodes_used_q + NW'(1);
            if (ver_q == 11'd1) v1_ok_d = 1'b1;
            done_d       = 1'b1;
            res_d        = '0;
            res_d.status = STS_OK;
          end
        end
      end
      ST_UPD_SIB: begin
        ustk_we_sum = 1'b1;
        dep_d   = dep_q + DW'(1);
        n_re    = 1'b1;
        n_raddr = cur_q;
      end
      ST_UPD_WR: begin
        n_we    = 1'b1;
        n_waddr = id_n;
        if (ustk_dir_q[rs_idx]) n_wdata = {sum_n, ustk_sib_q[rs_idx], chid_q};
        else                    n_wdata = {sum_n, chid_q, ustk_sib_q[rs_idx]};
        chid_d  = id_n;
        chsum_d = sum_n;
        dep_d   = dep_m1;
        if (wr_last) begin
          vr_we        = 1'b1;
          vr_wdata     = id_n;
          nodes_used_d = id_n;
          if (ver_q == 11'd1) v1_ok_d = 1'b1;
          done_d       = 1'b1;
          res_d        = '0;
          res_d.status = STS_OK;
        end
      end
      ST_QRY_VISIT: begin
        if (!disjoint) begin
          n_re    = 1'b1;
          n_raddr = cur_q;
        end else if (qsp_empty) begin
          done_d          = 1'b1;
          res_d           = '0;
          res_d.range_sum = acc_q;
          res_d.status    = STS_OK;
        end else begin
          cur_d = qstk_node_q[qr_idx];
          lo_d  = qstk_lo_q[qr_idx];
          hi_d  = qstk_hi_q[qr_idx];
          qsp_d = qsp_m1;
        end
      end
      ST_QRY_NODE: begin
        if (covered) begin
          acc_d = acc_n;
          if (qsp_empty) begin
            done_d          = 1'b1;
            res_d           = '0;
            res_d.range_sum = acc_n;
            res_d.status    = STS_OK;
          end else begin
            cur_d = qstk_node_q[qr_idx];
            lo_d  = qstk_lo_q[qr_idx];
            hi_d  = qstk_hi_q[qr_idx];
            qsp_d = qsp_m1;
          end
        end else begin
          // right half waits on the stack, walk the left half first
          qstk_push = 1'b1;
          qsp_d     = qsp_q + DW'(1);
          cur_d     = n_left;
          hi_d      = mid;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ustk_we_link) begin
      ustk_dir_q[ws_idx] <= ustk_dir_w;
      ustk_sib_q[ws_idx] <= ustk_sib_w;
    end
    if (ustk_we_sum) begin
      ustk_sum_q[ws_idx] <= n_sum;
    end
    if (qstk_push) begin
      qstk_node_q[qp_idx] <= n_right;
      qstk_lo_q[qp_idx]   <= mid + PW'(1);
      qstk_hi_q[qp_idx]   <= hi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; ver_q <= ver_d; vaddr_q <= vaddr_d; pos_q <= pos_d;
    a_q <= a_d; b_q <= b_d; lo_q <= lo_d; hi_q <= hi_d; val_q <= val_d;
    acc_q <= acc_d; chsum_q <= chsum_d; cur_q <= cur_d; chid_q <= chid_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      nodes_used_q <= '0;
      ver_total_q  <= VW'(1);
      v1_ok_q      <= 1'b0;
      done_q       <= 1'b0;
      dep_q        <= '0;
      qsp_q        <= '0;
    end else begin
      state_q      <= state_d;
      nodes_used_q <= nodes_used_d;
      ver_total_q  <= ver_total_d;
      v1_ok_q      <= v1_ok_d;
      done_q       <= done_d;
      dep_q        <= dep_d;
      qsp_q        <= qsp_d;
    end
  end

  // element count register, clamped to the legal range
  logic [PW-1:0] cfg_ext;
  assign cfg_ext = PW'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecount_q <= PW'(ECNT_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_ext == '0)                      ecount_q <= PW'(1);
      else if (cfg_ext > PW'(MAX_POSITIONS))  ecount_q <= PW'(MAX_POSITIONS);
      else                                    ecount_q <= cfg_ext;
    end
  end

  a_pool_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 nodes_used_q >= $past(nodes_used_q))
    else $error("node pool count went backwards");

  a_no_null_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_we |-> n_waddr != '0)
    else $error("write to the null node");

  a_ver_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ver_total_q >= VW'(1) && ver_total_q <= VW'(MAX_VERSIONS))
    else $error("version count out of range");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word while still busy");

  a_qstack_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstk_push |-> qsp_q < DW'(H))
    else $error("query stack overflow");

endmodule
`default_nettype wire
